[design/fbc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants for the fp32 / half / bfloat16 converter.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FmtW  = 2;
  localparam int unsigned ErrW  = 2;

  localparam logic [FmtW-1:0] FmtFp32 = 2'd0;
  localparam logic [FmtW-1:0] FmtHalf = 2'd1;
  localparam logic [FmtW-1:0] FmtBf16 = 2'd2;

  localparam logic ToFp32   = 1'b0;
  localparam logic FromFp32 = 1'b1;

  localparam logic [ErrW-1:0] ErrOk       = 2'd0;
  localparam logic [ErrW-1:0] ErrNonFin   = 2'd1;
  localparam logic [ErrW-1:0] ErrOverflow = 2'd2;

  localparam logic [7:0]  HalfBiasDiff = 8'd112;
  localparam logic [7:0]  HalfSubBase  = 8'd103;
  localparam logic [7:0]  HalfOvfExp   = 8'd143;
  localparam logic [7:0]  HalfZeroExp  = 8'd102;
  localparam logic [7:0]  HalfShBase   = 8'd126;
  localparam logic [23:0] HalfRndHalf  = 24'h000FFF;
  localparam logic [31:0] Bf16RndHalf  = 32'h00007FFF;

  typedef struct packed {
    logic             kind;
    logic [DataW-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] data_out;
    logic [ErrW-1:0]  error;
  } out_item_t;

endpackage : fbc_pkg
`default_nettype wire

[design/fp16_bf16_fp32_converter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fp16_bf16_fp32_converter
// Converts values between fp32 and a selectable stored encoding.
// ----------------------------------------------------------------------------
// Each item is captured in an input register, converted in one pass of
// combinational logic and held in a result register. An item is presented at
// the output from the result register and held there while out_stall_i is
// high. One item can be taken every cycle while the output is not stalled.
// A stalled result blocks the input only once the input register also holds
// an item. The stored encoding is selected by a two-bit register: fp32, IEEE
// half or bfloat16; the unused code acts as fp32. Widening returns fp32 bits,
// narrowing rounds to nearest even. Non-finite inputs and narrowing overflow
// are reported in the error field with the data forced to zero.
module fp16_bf16_fp32_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fbc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fbc_pkg::out_item_t out_item_o
);
  import fbc_pkg::*;

  logic [FmtW-1:0] fmt_q;
  logic            s1_valid_q;
  in_item_t        s1_item_q;
  logic            out_valid_q;
  out_item_t       out_item_q;
  logic            s1_adv;
  out_item_t       wide_res;
  out_item_t       narrow_res;
  out_item_t       conv_res;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtFp32;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_item_i;
    end
    if (s1_valid_q && s1_adv) begin
      out_item_q <= conv_res;
    end
  end

  fbc_widen u_widen (
    .fmt_i  (fmt_q),
    .data_i (s1_item_q.data_in),
    .res_o  (wide_res)
  );

  fbc_narrow u_narrow (
    .fmt_i  (fmt_q),
    .data_i (s1_item_q.data_in),
    .res_o  (narrow_res)
  );

  assign conv_res    = (s1_item_q.kind == FromFp32) ? narrow_res : wide_res;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_err_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.error != ErrOk) |-> (out_item_o.data_out == '0))
    else $error("result with error carries nonzero data");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.error == ErrOk) || (out_item_o.error == ErrNonFin) ||
                     (out_item_o.error == ErrOverflow)))
    else $error("undefined error code on result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule : fp16_bf16_fp32_converter
`default_nettype wire

[design/fbc_widen.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_widen
// Widens a stored encoding (fp32, half or bfloat16) to fp32 bits.
// ----------------------------------------------------------------------------
module fbc_widen (
  input  logic [1:0]        fmt_i,
  input  logic [31:0]       data_i,
  output fbc_pkg::out_item_t res_o
);
  import fbc_pkg::*;

  function automatic logic [3:0] lead_pos(input logic [9:0] v);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (v[i]) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

  logic       h_sign;
  logic [4:0] h_exp;
  logic [9:0] h_frac;
  logic [3:0] lead;
  logic [3:0] norm_sh;
  logic [9:0] norm_frac;
  logic [7:0] norm_exp;

  assign h_sign    = data_i[15];
  assign h_exp     = data_i[14:10];
  assign h_frac    = data_i[9:0];
  assign lead      = lead_pos(h_frac);
  assign norm_sh   = 4'd10 - lead;
  assign norm_frac = 10'(h_frac << norm_sh);
  assign norm_exp  = HalfSubBase + {4'b0, lead};

  always_comb begin
    res_o = '{data_out: '0, error: ErrOk};
    case (fmt_i)
      FmtHalf: begin
        if (&h_exp) begin
          res_o.error = ErrNonFin;
        end else if (h_exp == 5'd0) begin
          if (h_frac == 10'd0) begin
            res_o.data_out = {h_sign, 31'd0};
          end else begin
            res_o.data_out = {h_sign, norm_exp, norm_frac, 13'd0};
          end
        end else begin
          res_o.data_out = {h_sign, {3'd0, h_exp} + HalfBiasDiff, h_frac, 13'd0};
        end
      end
      FmtBf16: begin
        if (&data_i[14:7]) begin
          res_o.error = ErrNonFin;
        end else begin
          res_o.data_out = {data_i[15:0], 16'd0};
        end
      end
      default: begin
        if (&data_i[30:23]) begin
          res_o.error = ErrNonFin;
        end else begin
          res_o.data_out = data_i;
        end
      end
    endcase
  end

endmodule : fbc_widen
`default_nettype wire

[design/fbc_narrow.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_narrow
// Narrows fp32 bits to the stored encoding, rounding to nearest even.
// ----------------------------------------------------------------------------
module fbc_narrow (
  input  logic [1:0]        fmt_i,
  input  logic [31:0]       data_i,
  output fbc_pkg::out_item_t res_o
);
  import fbc_pkg::*;

  logic        sign;
  logic [7:0]  f_exp;
  logic [22:0] f_frac;
  logic [4:0]  he;
  logic [23:0] rn;
  logic [15:0] h_norm;
  logic [23:0] mant;
  logic [4:0]  sub_sh;
  logic [4:0]  gpos;
  logic [23:0] sub_q;
  logic [23:0] sticky_mask;
  logic        g_bit;
  logic        sticky;
  logic [10:0] sub_r;
  logic [15:0] h_res;
  logic [31:0] bf_t;

  assign sign   = data_i[31];
  assign f_exp  = data_i[30:23];
  assign f_frac = data_i[22:0];
  assign he     = 5'(f_exp - HalfBiasDiff);

  assign rn     = {1'b0, f_frac} + HalfRndHalf + {23'd0, f_frac[13]};
  assign h_norm = rn[23] ? {sign, 5'(he + 5'd1), 10'd0} : {sign, he, rn[22:13]};

  // Subnormal half results: shift amount runs from 14 to 24.
  assign mant        = {1'b1, f_frac};
  assign sub_sh      = 5'(HalfShBase - f_exp);
  assign gpos        = sub_sh - 5'd1;
  assign sub_q       = mant >> sub_sh;
  assign g_bit       = mant[gpos];
  assign sticky_mask = (24'd1 << gpos) - 24'd1;
  assign sticky      = |(mant & sticky_mask);
  assign sub_r       = sub_q[10:0] + {10'd0, g_bit & (sticky | sub_q[0])};

  always_comb begin
    if (f_exp >= HalfOvfExp) begin
      h_res = {sign, 5'h1F, 10'd0};
    end else if (f_exp < HalfZeroExp) begin
      h_res = {sign, 15'd0};
    end else if (f_exp <= HalfBiasDiff) begin
      h_res = {sign, 4'd0, sub_r};
    end else begin
      h_res = h_norm;
    end
  end

  assign bf_t = data_i + Bf16RndHalf + {31'd0, data_i[16]};

  always_comb begin
    res_o = '{data_out: '0, error: ErrOk};
    if (&f_exp) begin
      res_o.error = ErrNonFin;
    end else begin
      case (fmt_i)
        FmtHalf: begin
          if (&h_res[14:10]) begin
            res_o.error = ErrOverflow;
          end else begin
            res_o.data_out = {16'd0, h_res};
          end
        end
        FmtBf16: begin
          if (&bf_t[30:23]) begin
            res_o.error = ErrOverflow;
          end else begin
            res_o.data_out = {16'd0, bf_t[31:16]};
          end
        end
        default: begin
          res_o.data_out = data_i;
        end
      endcase
    end
  end

endmodule : fbc_narrow
`default_nettype wire
